FILE: hw/rtl/http_request_head_parser_unit_macros.svh
// Assertion macros for the request head parser.
`ifndef HTTP_REQUEST_HEAD_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define HRHP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hrhp assertion failed");
// Antecedent implies consequent in the next cycle.
`define HRHP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hrhp assertion failed");
`else
`define HRHP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HRHP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/hrhp_pkg.sv
// Types, constants and character class functions for the request head parser.
package hrhp_pkg;

    typedef enum logic [4:0] {
        PS_METHOD_START = 5'd0,
        PS_METHOD       = 5'd1,
        PS_URI_START    = 5'd2,
        PS_URI          = 5'd3,
        PS_VER_H        = 5'd4,
        PS_VER_T1       = 5'd5,
        PS_VER_T2       = 5'd6,
        PS_VER_P        = 5'd7,
        PS_VER_SLASH    = 5'd8,
        PS_MAJOR_START  = 5'd9,
        PS_MAJOR        = 5'd10,
        PS_MINOR_START  = 5'd11,
        PS_MINOR        = 5'd12,
        PS_LF_1         = 5'd13,
        PS_LINE_START   = 5'd14,
        PS_LWS          = 5'd15,
        PS_NAME         = 5'd16,
        PS_SPACE_VALUE  = 5'd17,
        PS_VALUE        = 5'd18,
        PS_LF_2         = 5'd19,
        PS_LF_3         = 5'd20
    } parse_state_t;

    typedef enum logic [1:0] {
        STATUS_PENDING = 2'd0,
        STATUS_ACCEPT  = 2'd1,
        STATUS_REJECT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_METHOD = 3'd1,
        CLS_URI    = 3'd2,
        CLS_NAME   = 3'd3,
        CLS_VALUE  = 3'd4
    } byte_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        byte_class_t byte_class;
        logic [7:0]  byte_out;
        logic        header_start;
        logic [15:0] version_major;
        logic [15:0] version_minor;
    } out_item_t;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CTL_LAST   = 8'h1F;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CTL_LAST) || (c == CHAR_DEL);
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        logic sep;
        case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
            8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D,
            8'h20, 8'h09: sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return sep;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_separator(c);
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_space_tab(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

    // v * 10 + digit, saturating at the 16-bit maximum; digit is the low nibble.
    function automatic logic [15:0] accumulate(input logic [15:0] v, input logic [7:0] c);
        logic [20:0] n;
        n = ({5'd0, v} << 3) + ({5'd0, v} << 1) + {17'd0, c[3:0]};
        return (n > {5'd0, COUNT_MAX}) ? COUNT_MAX : n[15:0];
    endfunction

endpackage

FILE: hw/rtl/hrhp_fsm.sv
// Parse state registers and the per-byte transition logic.
module hrhp_fsm
    import hrhp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    parse_state_t state_reg, state_next;
    logic         have_header_reg, have_header_next;
    logic [15:0]  major_reg, major_next;
    logic [15:0]  minor_reg, minor_next;
    status_t      verdict_reg, verdict_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= PS_METHOD_START;
            have_header_reg <= 1'b0;
            major_reg       <= '0;
            minor_reg       <= '0;
            verdict_reg     <= STATUS_PENDING;
        end else if (step) begin
            state_reg       <= state_next;
            have_header_reg <= have_header_next;
            major_reg       <= major_next;
            minor_reg       <= minor_next;
            verdict_reg     <= verdict_next;
        end
    end

    always_comb begin
        parse_state_t s;
        logic [7:0]   c;
        logic         bad;
        byte_class_t  cls;
        logic         hstart;

        c      = item.data_byte;
        bad    = 1'b0;
        cls    = CLS_NONE;
        hstart = 1'b0;

        // restart takes effect before the byte is judged
        if (item.restart) begin
            state_next       = PS_METHOD_START;
            have_header_next = 1'b0;
            major_next       = '0;
            minor_next       = '0;
            verdict_next     = STATUS_PENDING;
        end else begin
            state_next       = state_reg;
            have_header_next = have_header_reg;
            major_next       = major_reg;
            minor_next       = minor_reg;
            verdict_next     = verdict_reg;
        end
        s = state_next;

        if (verdict_next == STATUS_PENDING) begin
            case (state_next)
                PS_METHOD_START: begin
                    if (is_token(c)) begin
                        s = PS_METHOD; cls = CLS_METHOD;
                    end else bad = 1'b1;
                end
                PS_METHOD: begin
                    if (c == CHAR_SPACE) s = PS_URI_START;
                    else if (is_token(c)) cls = CLS_METHOD;
                    else bad = 1'b1;
                end
                PS_URI_START: begin
                    if (is_ctl(c)) bad = 1'b1;
                    else begin
                        s = PS_URI; cls = CLS_URI;
                    end
                end
                PS_URI: begin
                    if (c == CHAR_SPACE) s = PS_VER_H;
                    else if (is_ctl(c)) bad = 1'b1;
                    else cls = CLS_URI;
                end
                PS_VER_H: begin
                    if (c == CHAR_H) s = PS_VER_T1; else bad = 1'b1;
                end
                PS_VER_T1: begin
                    if (c == CHAR_T) s = PS_VER_T2; else bad = 1'b1;
                end
                PS_VER_T2: begin
                    if (c == CHAR_T) s = PS_VER_P; else bad = 1'b1;
                end
                PS_VER_P: begin
                    if (c == CHAR_P) s = PS_VER_SLASH; else bad = 1'b1;
                end
                PS_VER_SLASH: begin
                    if (c == CHAR_SLASH) begin
                        major_next = '0; minor_next = '0; s = PS_MAJOR_START;
                    end else bad = 1'b1;
                end
                PS_MAJOR_START: begin
                    if (is_dec_digit(c)) begin
                        major_next = accumulate(major_next, c); s = PS_MAJOR;
                    end else bad = 1'b1;
                end
                PS_MAJOR: begin
                    if (c == CHAR_DOT) s = PS_MINOR_START;
                    else if (is_dec_digit(c)) major_next = accumulate(major_next, c);
                    else bad = 1'b1;
                end
                PS_MINOR_START: begin
                    if (is_dec_digit(c)) begin
                        minor_next = accumulate(minor_next, c); s = PS_MINOR;
                    end else bad = 1'b1;
                end
                PS_MINOR: begin
                    if (c == CHAR_CR) s = PS_LF_1;
                    else if (is_dec_digit(c)) minor_next = accumulate(minor_next, c);
                    else bad = 1'b1;
                end
                PS_LF_1: begin
                    if (c == CHAR_LF) s = PS_LINE_START; else bad = 1'b1;
                end
                PS_LINE_START: begin
                    if (c == CHAR_CR) s = PS_LF_3;
                    else if (have_header_next && is_space_tab(c)) s = PS_LWS;
                    else if (is_token(c)) begin
                        have_header_next = 1'b1; hstart = 1'b1;
                        cls = CLS_NAME; s = PS_NAME;
                    end else bad = 1'b1;
                end
                PS_LWS: begin
                    if (c == CHAR_CR) s = PS_LF_2;
                    else if (is_space_tab(c)) s = PS_LWS;
                    else if (is_ctl(c)) bad = 1'b1;
                    else begin
                        s = PS_VALUE; cls = CLS_VALUE;
                    end
                end
                PS_NAME: begin
                    if (c == CHAR_COLON) s = PS_SPACE_VALUE;
                    else if (is_token(c)) cls = CLS_NAME;
                    else bad = 1'b1;
                end
                PS_SPACE_VALUE: begin
                    if (c == CHAR_SPACE) s = PS_VALUE; else bad = 1'b1;
                end
                PS_VALUE: begin
                    if (c == CHAR_CR) s = PS_LF_2;
                    else if (is_ctl(c)) bad = 1'b1;
                    else cls = CLS_VALUE;
                end
                PS_LF_2: begin
                    if (c == CHAR_LF) s = PS_LINE_START; else bad = 1'b1;
                end
                PS_LF_3: begin
                    if (c == CHAR_LF) verdict_next = STATUS_ACCEPT; else bad = 1'b1;
                end
                default: bad = 1'b1;
            endcase

            // a rejected byte leaves the parse state where it was
            if (bad) begin
                verdict_next = STATUS_REJECT;
                cls          = CLS_NONE;
                hstart       = 1'b0;
            end else begin
                state_next = s;
            end
        end

        result.status        = verdict_next;
        result.byte_class    = cls;
        result.byte_out      = c;
        result.header_start  = hstart;
        result.version_major = major_next;
        result.version_minor = minor_next;
    end

endmodule

FILE: hw/rtl/http_request_head_parser_unit.sv
// Top level of the request head parser: input register, parser and result register.
// An input byte is registered in the input register and then in the result register, which
// offers it on m_valid; a stall on m_ready can hold it in either register.
// Throughput: one byte per cycle while m_ready stays high; the parser step is a single state
// transition plus a times-ten accumulate, evaluated between the input and result registers.
// Reset (aresetn low, synchronous): both pipeline registers empty, parser at method
// start, version counts cleared, verdict pending.
`include "http_request_head_parser_unit_macros.svh"

module http_request_head_parser_unit
    import hrhp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    // byte input channel
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    // result channel
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Input register: holds the byte waiting to be judged.
    logic      in_valid_reg;
    in_item_t  in_data_reg;

    // Result register: holds the judged byte until the consumer takes it.
    logic      out_valid_reg;
    out_item_t out_data_reg;

    out_item_t step_result;
    logic      advance;
    logic      step;

    // Advance whenever the result register is empty or being drained this cycle.
    assign advance = !out_valid_reg || m_ready;
    // The parser state moves only when a byte passes from input to result register.
    assign step    = in_valid_reg && advance;
    // Take a new byte whenever the input register is empty or moving on.
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload register: capture on every input transfer, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    hrhp_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Hold the result while the consumer stalls; load it on every parser step.
    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Every parser step leaves a valid result in the result register in the next cycle.
    `HRHP_ASSERT_NEXT(a_step_gives_result, aclk, aresetn, step, out_valid_reg)
    // A drained result register with nothing behind it goes empty.
    `HRHP_ASSERT_NEXT(a_drain_empties, aclk, aresetn,
        out_valid_reg && m_ready && !in_valid_reg, !out_valid_reg)
    // Tagged bytes only appear while the verdict is still pending.
    `HRHP_ASSERT_IMP(a_class_pending, aclk, aresetn,
        out_valid_reg && (out_data_reg.byte_class != CLS_NONE),
        out_data_reg.status == STATUS_PENDING)
    // A header start is always the first byte of a header name.
    `HRHP_ASSERT_IMP(a_hstart_is_name, aclk, aresetn,
        out_valid_reg && out_data_reg.header_start,
        out_data_reg.byte_class == CLS_NAME)

endmodule
